// File: rtl/rsm_pkg.sv
// Shared types, codes and sizing constants of the row span merge unit.
package rsm_pkg;

    localparam int MAX_RECTS_DEF = 16;
    localparam int RESULT_LIMIT  = 16;
    localparam int KW            = $clog2(RESULT_LIMIT);

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic        [14:0] wide;
        logic        [14:0] tall;
    } t_rect;

    typedef struct packed {
        logic        [1:0]  status;
        logic signed [15:0] span_left;
        logic        [16:0] span_wide;
        logic               last;
    } t_result;

    function automatic t_result make_result(logic [1:0] status, logic signed [15:0] left,
                                            logic [16:0] wide, logic last);
        t_result r;
        r.status    = status;
        r.span_left = left;
        r.span_wide = wide;
        r.last      = last;
        return r;
    endfunction

endpackage

// File: rtl/row_span_merge_unit.sv
// Top level of the row span merge unit: sequencer, rectangle store, output register.
//
// Input channel (i_in_valid / o_in_stall) carries one transaction per op:
// load a rectangle, query the merged spans of one row, or clear the store.
// Output channel (o_out_valid / i_out_stall) returns results; o_last marks
// the final result of each input transaction.
// A load, clear or unused op gives a single result. A query scans the
// stored rectangles once per selected rectangle, and once more to find
// none left, through the single read port of the store. The selection
// scan over the store sets the length of a query.
// The input stalls whenever a transaction is in progress; a final result
// held in the output register does not block the next input.
// Reset empties the store (count to zero) and clears both channels.
// While i_out_stall is high and a result is held, the output register keeps
// that result and the sequencer waits with the next span.
module row_span_merge_unit #(
    parameter int MAX_RECTS = rsm_pkg::MAX_RECTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_op,
    input  logic signed [15:0] i_rect_left,
    input  logic signed [15:0] i_rect_top,
    input  logic [14:0]        i_rect_wide,
    input  logic [14:0]        i_rect_tall,
    input  logic signed [15:0] i_query_row,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [15:0] o_span_left,
    output logic [16:0]        o_span_wide,
    output logic               o_last
);

    localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CW = $clog2(MAX_RECTS + 1);

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    rsm_pkg::t_rect    wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    rsm_pkg::t_rect    rd_data;
    logic              res_push;
    logic              res_rdy;
    rsm_pkg::t_result  res;

    logic              r_o_vld, n_o_vld;
    rsm_pkg::t_result  r_o;

    rsm_ctrl #(
        .MAX_RECTS (MAX_RECTS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_rect_left (i_rect_left),
        .i_rect_top  (i_rect_top),
        .i_rect_wide (i_rect_wide),
        .i_rect_tall (i_rect_tall),
        .i_query_row (i_query_row),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_res_push  (res_push),
        .i_res_rdy   (res_rdy),
        .o_res       (res)
    );

    rsm_store #(
        .DEPTH (MAX_RECTS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Take a new result when the register is empty or being drained.
    assign res_rdy = !r_o_vld || !i_out_stall;
    assign n_o_vld = res_rdy ? res_push : r_o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= n_o_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push && res_rdy) begin
            r_o <= res;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_status    = r_o.status;
    assign o_span_left = r_o.span_left;
    assign o_span_wide = r_o.span_wide;
    assign o_last      = r_o.last;

endmodule

// File: rtl/rsm_store.sv
// Rectangle store: one write port, one read port with registered read data.
module rsm_store #(
    parameter int DEPTH = rsm_pkg::MAX_RECTS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  rsm_pkg::t_rect  i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output rsm_pkg::t_rect  o_rd_data
);

    rsm_pkg::t_rect r_mem [DEPTH];
    rsm_pkg::t_rect r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/rsm_ctrl.sv
// Sequencer: loads, clears, and the scan-select-merge loop of a row query.
module rsm_ctrl #(
    parameter int MAX_RECTS = rsm_pkg::MAX_RECTS_DEF,
    parameter int AW        = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1,
    parameter int CW        = $clog2(MAX_RECTS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_op,
    input  logic signed [15:0]  i_rect_left,
    input  logic signed [15:0]  i_rect_top,
    input  logic [14:0]         i_rect_wide,
    input  logic [14:0]         i_rect_tall,
    input  logic signed [15:0]  i_query_row,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output rsm_pkg::t_rect      o_wr_data,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr,
    input  rsm_pkg::t_rect      i_rd_data,
    output logic                o_res_push,
    input  logic                i_res_rdy,
    output rsm_pkg::t_result    o_res
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_PICK = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    t_state                     r_ret, n_ret;
    logic [CW-1:0]              r_count, n_count;
    logic signed [15:0]         r_row, n_row;
    logic [CW-1:0]              r_idx, n_idx;
    logic                       r_rd_vld, n_rd_vld;
    logic [AW-1:0]              r_rd_idx, n_rd_idx;
    logic [MAX_RECTS-1:0]       r_used, n_used;
    logic                       r_found, n_found;
    logic [AW-1:0]              r_best_idx, n_best_idx;
    logic signed [15:0]         r_best_lo, n_best_lo;
    logic signed [17:0]         r_best_hi, n_best_hi;
    logic                       r_open, n_open;
    logic signed [15:0]         r_cur_lo, n_cur_lo;
    logic signed [17:0]         r_cur_hi, n_cur_hi;
    logic [rsm_pkg::KW-1:0]     r_k, n_k;
    rsm_pkg::t_result           r_res, n_res;

    logic                       accept;
    logic                       full;
    logic signed [15:0]         rd_left;
    logic signed [15:0]         rd_top;
    logic signed [16:0]         rd_bot;
    logic signed [17:0]         rd_hi;
    logic                       hit;
    logic                       better;
    logic [16:0]                cur_wide;
    logic                       cap_last;

    assign accept   = i_in_valid && !o_in_stall;
    assign full     = (r_count == CW'(MAX_RECTS));
    assign o_in_stall = (r_state != S_IDLE);

    assign o_wr_en        = accept && (i_op == rsm_pkg::OP_LOAD) && !full;
    assign o_wr_addr      = r_count[AW-1:0];
    assign o_wr_data.left = i_rect_left;
    assign o_wr_data.top  = i_rect_top;
    assign o_wr_data.wide = i_rect_wide;
    assign o_wr_data.tall = i_rect_tall;

    // Reads happen only while scanning, writes only when idle: no overlap.
    assign o_rd_en   = (r_state == S_SCAN) && (r_idx < r_count);
    assign o_rd_addr = r_idx[AW-1:0];

    assign rd_left = i_rd_data.left;
    assign rd_top  = i_rd_data.top;
    assign rd_bot  = {rd_top[15], rd_top} + $signed({2'b00, i_rd_data.tall});
    assign rd_hi   = {{2{rd_left[15]}}, rd_left} + $signed({3'b000, i_rd_data.wide});
    assign hit     = r_rd_vld && (i_rd_data.tall != '0) && (r_row >= rd_top)
                     && ($signed({r_row[15], r_row}) < rd_bot) && !r_used[r_rd_idx];
    assign better  = !r_found || (rd_left < r_best_lo);

    assign cur_wide = 17'(r_cur_hi - {{2{r_cur_lo[15]}}, r_cur_lo});
    // The span that fills the last result slot ends the transaction.
    assign cap_last = (r_k == rsm_pkg::KW'(rsm_pkg::RESULT_LIMIT - 1));

    assign o_res_push = (r_state == S_EMIT) && i_res_rdy;
    assign o_res      = r_res;

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_count    = r_count;
        n_row      = r_row;
        n_idx      = r_idx;
        n_rd_vld   = o_rd_en;
        n_rd_idx   = r_idx[AW-1:0];
        n_used     = r_used;
        n_found    = r_found;
        n_best_idx = r_best_idx;
        n_best_lo  = r_best_lo;
        n_best_hi  = r_best_hi;
        n_open     = r_open;
        n_cur_lo   = r_cur_lo;
        n_cur_hi   = r_cur_hi;
        n_k        = r_k;
        n_res      = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EMIT;
                    n_ret   = S_IDLE;
                    n_res   = rsm_pkg::make_result(rsm_pkg::ST_OK, '0, '0, 1'b1);
                    unique case (i_op)
                        rsm_pkg::OP_LOAD: begin
                            if (full) begin
                                n_res = rsm_pkg::make_result(rsm_pkg::ST_FULL, '0, '0, 1'b1);
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        rsm_pkg::OP_QUERY: begin
                            if (r_count == '0) begin
                                n_res = rsm_pkg::make_result(rsm_pkg::ST_EMPTY, '0, '0, 1'b1);
                            end else begin
                                n_state = S_SCAN;
                                n_row   = i_query_row;
                                n_idx   = '0;
                                n_used  = '0;
                                n_found = 1'b0;
                                n_open  = 1'b0;
                                n_k     = '0;
                            end
                        end
                        rsm_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (o_rd_en) begin
                    n_idx = r_idx + 1'b1;
                end
                // Keep the smallest left among unused covering entries.
                if (hit && better) begin
                    n_found    = 1'b1;
                    n_best_idx = r_rd_idx;
                    n_best_lo  = rd_left;
                    n_best_hi  = rd_hi;
                end
                if ((r_idx == r_count) && !r_rd_vld) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (!r_found) begin
                    n_state = S_EMIT;
                    n_ret   = S_IDLE;
                    if (r_open) begin
                        n_res = rsm_pkg::make_result(rsm_pkg::ST_OK, r_cur_lo, cur_wide, 1'b1);
                    end else begin
                        n_res = rsm_pkg::make_result(rsm_pkg::ST_EMPTY, '0, '0, 1'b1);
                    end
                end else begin
                    n_used[r_best_idx] = 1'b1;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = S_SCAN;
                    if (r_open && ($signed({{2{r_best_lo[15]}}, r_best_lo}) <= r_cur_hi)) begin
                        if (r_best_hi > r_cur_hi) begin
                            n_cur_hi = r_best_hi;
                        end
                    end else begin
                        n_open   = 1'b1;
                        n_cur_lo = r_best_lo;
                        n_cur_hi = r_best_hi;
                        if (r_open) begin
                            // Close the running span and emit it.
                            n_res   = rsm_pkg::make_result(rsm_pkg::ST_OK, r_cur_lo, cur_wide,
                                                           cap_last);
                            n_k     = r_k + 1'b1;
                            n_state = S_EMIT;
                            n_ret   = cap_last ? S_IDLE : S_SCAN;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (i_res_rdy) begin
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_idx      <= n_idx;
        r_rd_idx   <= n_rd_idx;
        r_used     <= n_used;
        r_found    <= n_found;
        r_best_idx <= n_best_idx;
        r_best_lo  <= n_best_lo;
        r_best_hi  <= n_best_hi;
        r_open     <= n_open;
        r_cur_lo   <= n_cur_lo;
        r_cur_hi   <= n_cur_hi;
        r_k        <= n_k;
        r_res      <= n_res;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RECTS))
        else $error("stored count beyond capacity");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ({1'b0, r_rd_idx} < {1'b0, r_count}))
        else $error("read returned for an entry beyond the stored count");

    a_no_wr_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !o_wr_en && $stable(r_count))
        else $error("store changed during a query scan");

    a_pick_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK && r_found) |=> r_used[$past(r_best_idx)])
        else $error("selected entry not marked as used");

endmodule
